### rtl/core/swrl_pkg.sv
// Shared types, codes and constants for the sliding window rate limiter.
// No dependencies; swrl_ctrl and sliding_window_rate_limiter_unit refer to it by scoped names.
package swrl_pkg;

    // Default sizes, handed to the top level parameters
    localparam int DEF_SENDERS       = 256;
    localparam int DEF_HISTORY_DEPTH = 64;

    // Fixed field widths
    localparam int SENDER_W    = 8;
    localparam int TICK_W      = 32;
    localparam int LIMIT_W     = 16;
    localparam int COUNT_OUT_W = 7;

    // Stream port widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_TICKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MESSAGES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_COMMANDS = 2'd2;

    localparam logic [TICK_W-1:0]  WINDOW_RESET       = 32'd10000;
    localparam logic [LIMIT_W-1:0] MAX_MESSAGES_RESET = 16'd10;
    localparam logic [LIMIT_W-1:0] MAX_COMMANDS_RESET = 16'd10;

    // Item codes
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_CHECK  = 1'b1;
    localparam logic KIND_MSG   = 1'b0;
    localparam logic KIND_CMD   = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0]  window_ticks;
        logic [LIMIT_W-1:0] max_messages;
        logic [LIMIT_W-1:0] max_commands;
    } cfg_t;

    typedef struct packed {
        logic                   history_full;
        logic                   over_limit;
        logic [COUNT_OUT_W-1:0] recent_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_FETCH,
        ST_TEST,
        ST_WB
    } ctrl_state_t;

endpackage

### rtl/core/swrl_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/swrl_ctrl.sv
// Sequencer for the rate limiter: clears ring state after reset, then reads,
// updates, prunes and writes back one ring per item. Uses swrl_pkg.
module swrl_ctrl #(
    parameter int SENDERS       = swrl_pkg::DEF_SENDERS,
    parameter int HISTORY_DEPTH = swrl_pkg::DEF_HISTORY_DEPTH,
    localparam int RINGS   = 2 * SENDERS,
    localparam int RING_W  = $clog2(RINGS),
    localparam int PTR_W   = $clog2(HISTORY_DEPTH),
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1),
    localparam int META_W  = PTR_W + CNT_W,
    localparam int SADDR_W = $clog2(RINGS * HISTORY_DEPTH)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Item in
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_action,
    input  logic                            in_kind,
    input  logic [swrl_pkg::SENDER_W-1:0]   in_sender,
    input  logic [swrl_pkg::TICK_W-1:0]     in_now,
    input  swrl_pkg::cfg_t                  cfg,
    // Result out
    output logic                            res_valid,
    input  logic                            res_ready,
    output swrl_pkg::result_t               res,
    // Ring state memory
    output logic                            meta_we,
    output logic [RING_W-1:0]               meta_waddr,
    output logic [META_W-1:0]               meta_wdata,
    output logic                            meta_re,
    output logic [RING_W-1:0]               meta_raddr,
    input  logic [META_W-1:0]               meta_rdata,
    // Stamp memory
    output logic                            stamp_we,
    output logic [SADDR_W-1:0]              stamp_waddr,
    output logic [swrl_pkg::TICK_W-1:0]     stamp_wdata,
    output logic                            stamp_re,
    output logic [SADDR_W-1:0]              stamp_raddr,
    input  logic [swrl_pkg::TICK_W-1:0]     stamp_rdata
);

    swrl_pkg::ctrl_state_t state_reg, state_next;

    logic [RING_W-1:0]               ring_reg, ring_next;
    logic [SADDR_W-1:0]              base_reg, base_next;
    logic                            action_reg, action_next;
    logic                            kind_reg, kind_next;
    logic                            ok_reg, ok_next;
    logic [swrl_pkg::TICK_W-1:0]     now_reg, now_next;
    logic [PTR_W-1:0]                oldest_reg, oldest_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            full_reg, full_next;
    logic [RING_W-1:0]               clr_reg, clr_next;

    logic [PTR_W-1:0]                meta_oldest;
    logic [CNT_W-1:0]                meta_count;
    logic [PTR_W:0]                  pos_sum;
    logic [PTR_W-1:0]                pos;
    logic [RING_W-1:0]               ring_in;
    logic                            ok_in;
    logic [swrl_pkg::TICK_W-1:0]     age;
    logic [swrl_pkg::LIMIT_W-1:0]    limit;
    logic [31:0]                     count_wide;

    // Step a ring position with wrap
    function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(HISTORY_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign {meta_oldest, meta_count} = meta_rdata;

    // Ring index and range check of the incoming item
    assign ok_in   = (32'(in_sender) < 32'(SENDERS));
    assign ring_in = RING_W'(in_sender) + (in_kind ? RING_W'(SENDERS) : RING_W'(0));

    // Free slot position of the ring being recorded into
    assign pos_sum = (PTR_W+1)'(meta_oldest) + (PTR_W+1)'(meta_count);
    assign pos     = (pos_sum >= (PTR_W+1)'(HISTORY_DEPTH))
                   ? PTR_W'(pos_sum - (PTR_W+1)'(HISTORY_DEPTH))
                   : PTR_W'(pos_sum);

    assign age   = now_reg - stamp_rdata;
    assign limit = (kind_reg == swrl_pkg::KIND_CMD) ? cfg.max_commands : cfg.max_messages;

    // Result from the written-back ring state
    assign count_wide        = 32'(count_reg);
    assign res.recent_count  = count_wide[swrl_pkg::COUNT_OUT_W-1:0];
    assign res.over_limit    = (action_reg == swrl_pkg::ACT_CHECK)
                             && (17'(count_reg) > 17'(limit));
    assign res.history_full  = full_reg;

    // State and item registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swrl_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        ring_reg   <= ring_next;
        base_reg   <= base_next;
        action_reg <= action_next;
        kind_reg   <= kind_next;
        ok_reg     <= ok_next;
        now_reg    <= now_next;
        oldest_reg <= oldest_next;
        count_reg  <= count_next;
        full_reg   <= full_next;
    end

    // Next state and memory control
    always_comb begin
        state_next  = state_reg;
        ring_next   = ring_reg;
        base_next   = base_reg;
        action_next = action_reg;
        kind_next   = kind_reg;
        ok_next     = ok_reg;
        now_next    = now_reg;
        oldest_next = oldest_reg;
        count_next  = count_reg;
        full_next   = full_reg;
        clr_next    = clr_reg;

        in_ready    = 1'b0;
        res_valid   = 1'b0;
        meta_we     = 1'b0;
        meta_waddr  = ring_reg;
        meta_wdata  = {oldest_reg, count_reg};
        meta_re     = 1'b0;
        meta_raddr  = ring_reg;
        stamp_we    = 1'b0;
        stamp_waddr = base_reg + SADDR_W'(pos);
        stamp_wdata = now_reg;
        stamp_re    = 1'b0;
        stamp_raddr = base_reg + SADDR_W'(oldest_reg);

        unique case (state_reg)
            swrl_pkg::ST_CLEAR: begin
                // Zero one ring's state per cycle
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                meta_wdata = '0;
                clr_next   = clr_reg + RING_W'(1);
                if (clr_reg == RING_W'(RINGS - 1)) begin
                    state_next = swrl_pkg::ST_IDLE;
                end
            end
            swrl_pkg::ST_IDLE: begin
                // Take an item; unknown senders report all zero
                in_ready = 1'b1;
                if (in_valid) begin
                    ring_next   = ring_in;
                    base_next   = SADDR_W'(ring_in) * SADDR_W'(HISTORY_DEPTH);
                    action_next = in_action;
                    kind_next   = in_kind;
                    ok_next     = ok_in;
                    now_next    = in_now;
                    count_next  = '0;
                    full_next   = 1'b0;
                    state_next  = ok_in ? swrl_pkg::ST_READ : swrl_pkg::ST_WB;
                end
            end
            swrl_pkg::ST_READ: begin
                meta_re    = 1'b1;
                state_next = swrl_pkg::ST_UPDATE;
            end
            swrl_pkg::ST_UPDATE: begin
                // Append the stamp on a record; overwrite the oldest when full
                oldest_next = meta_oldest;
                count_next  = meta_count;
                if (action_reg == swrl_pkg::ACT_RECORD) begin
                    stamp_we = 1'b1;
                    if (meta_count >= CNT_W'(HISTORY_DEPTH)) begin
                        stamp_waddr = base_reg + SADDR_W'(meta_oldest);
                        oldest_next = ptr_step(meta_oldest);
                        full_next   = 1'b1;
                    end else begin
                        count_next = meta_count + CNT_W'(1);
                    end
                end
                state_next = swrl_pkg::ST_FETCH;
            end
            swrl_pkg::ST_FETCH: begin
                // Read the oldest stamp unless the ring is empty
                if (count_reg == '0) begin
                    state_next = swrl_pkg::ST_WB;
                end else begin
                    stamp_re   = 1'b1;
                    state_next = swrl_pkg::ST_TEST;
                end
            end
            swrl_pkg::ST_TEST: begin
                // Drop a stale stamp and look at the next one
                if (age > cfg.window_ticks) begin
                    oldest_next = ptr_step(oldest_reg);
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = swrl_pkg::ST_FETCH;
                end else begin
                    state_next = swrl_pkg::ST_WB;
                end
            end
            swrl_pkg::ST_WB: begin
                // Write back the ring state and hand over the result
                meta_we   = ok_reg;
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = swrl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swrl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/sliding_window_rate_limiter_unit.sv
// Per-sender sliding-window log rate limiter. For each accepted item the sequencer reads
// and updates the ring state, pops stale stamps from the oldest end and writes the state
// back. A new item is taken only after the result leaves the sequencer, so items are
// handled one at a time; a stalled result holds the sequencer. After reset a clearing pass
// zeroes the state of all 2*SENDERS rings; no item is taken until it ends. Config resets
// to window 10000, thresholds 10. Uses swrl_pkg, swrl_ctrl and swrl_ram.
module sliding_window_rate_limiter_unit #(
    parameter int SENDERS       = swrl_pkg::DEF_SENDERS,
    parameter int HISTORY_DEPTH = swrl_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Item in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swrl_pkg::S_TDATA_W-1:0]    s_tdata,  // sender[7:0], now_ticks[39:8]
    input  logic [swrl_pkg::S_TUSER_W-1:0]    s_tuser,  // action[0], stream_kind[1]
    // Result out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swrl_pkg::M_TDATA_W-1:0]    m_tdata,  // recent_count[6:0], over_limit[7],
                                                        // history_full[8], zero[15:9]
    // Configuration writes
    input  logic                              cfg_we,
    input  logic [swrl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [swrl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int RINGS   = 2 * SENDERS;
    localparam int RING_W  = $clog2(RINGS);
    localparam int PTR_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int META_W  = PTR_W + CNT_W;
    localparam int SADDR_W = $clog2(RINGS * HISTORY_DEPTH);

    swrl_pkg::cfg_t    cfg_reg;
    swrl_pkg::result_t res;
    swrl_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              res_valid;
    logic              res_ready;

    logic                        meta_we, meta_re;
    logic [RING_W-1:0]           meta_waddr, meta_raddr;
    logic [META_W-1:0]           meta_wdata, meta_rdata;
    logic                        stamp_we, stamp_re;
    logic [SADDR_W-1:0]          stamp_waddr, stamp_raddr;
    logic [swrl_pkg::TICK_W-1:0] stamp_wdata, stamp_rdata;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_ticks <= swrl_pkg::WINDOW_RESET;
            cfg_reg.max_messages <= swrl_pkg::MAX_MESSAGES_RESET;
            cfg_reg.max_commands <= swrl_pkg::MAX_COMMANDS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                swrl_pkg::CFG_WINDOW_TICKS: cfg_reg.window_ticks <= cfg_wdata;
                swrl_pkg::CFG_MAX_MESSAGES:
                    cfg_reg.max_messages <= cfg_wdata[swrl_pkg::LIMIT_W-1:0];
                swrl_pkg::CFG_MAX_COMMANDS:
                    cfg_reg.max_commands <= cfg_wdata[swrl_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = swrl_pkg::M_TDATA_W'(out_reg);

    swrl_ctrl #(
        .SENDERS       (SENDERS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser[0]),
        .in_kind     (s_tuser[1]),
        .in_sender   (s_tdata[7:0]),
        .in_now      (s_tdata[39:8]),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .meta_we     (meta_we),
        .meta_waddr  (meta_waddr),
        .meta_wdata  (meta_wdata),
        .meta_re     (meta_re),
        .meta_raddr  (meta_raddr),
        .meta_rdata  (meta_rdata),
        .stamp_we    (stamp_we),
        .stamp_waddr (stamp_waddr),
        .stamp_wdata (stamp_wdata),
        .stamp_re    (stamp_re),
        .stamp_raddr (stamp_raddr),
        .stamp_rdata (stamp_rdata)
    );

    // Ring state: oldest position and live count per ring
    swrl_ram #(
        .WIDTH (META_W),
        .DEPTH (RINGS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // Time stamp history rings
    swrl_ram #(
        .WIDTH (swrl_pkg::TICK_W),
        .DEPTH (RINGS * HISTORY_DEPTH)
    ) u_stamp_ram (
        .aclk  (aclk),
        .we    (stamp_we),
        .waddr (stamp_waddr),
        .wdata (stamp_wdata),
        .re    (stamp_re),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

endmodule

### dv/tb_sliding_window_rate_limiter_unit.sv
// Self-checking bench for sliding_window_rate_limiter_unit: directed rows, then random
// phases under several window and threshold settings, with bursty input and result stalls.
// Depends on swrl_pkg and the unit's RTL only.
module tb_sliding_window_rate_limiter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import swrl_pkg::*;

    localparam int NUM_SENDERS = DEF_SENDERS;
    localparam int RING_DEPTH  = DEF_HISTORY_DEPTH;
    localparam int NUM_RINGS   = 2 * NUM_SENDERS;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_AFTER  = 60;
    localparam int HOLD_CYCLES = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // sender[7:0], now_ticks[39:8]
    logic [S_TUSER_W-1:0]  s_tuser   = '0;  // action[0], stream_kind[1]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // recent_count[6:0], over_limit[7],
                                            // history_full[8], zero[15:9]
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    sliding_window_rate_limiter_unit #(
        .SENDERS      (NUM_SENDERS),
        .HISTORY_DEPTH(RING_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // Shadow of the limiter: stamp rings, oldest positions, live counts, registers
    logic [TICK_W-1:0]  stamp_log [NUM_RINGS][RING_DEPTH];
    int                 head_slot [NUM_RINGS];
    int                 live_cnt  [NUM_RINGS];
    logic [TICK_W-1:0]  window_len = WINDOW_RESET;
    logic [LIMIT_W-1:0] max_msgs   = MAX_MESSAGES_RESET;
    logic [LIMIT_W-1:0] max_cmds   = MAX_COMMANDS_RESET;

    result_t tallies_due [$];
    int      failures     = 0;
    int      results_seen = 0;
    int      burst_left   = 0;

    typedef struct {
        logic        act;
        logic        kind;
        logic [7:0]  sndr;
        logic [31:0] now;
        bit          typed;
        int          cnt;
        bit          over;
        bit          full;
    } probe_t;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Pop stale stamps from the oldest end, stop at the first one inside the window
    function automatic void drop_stale(int ring, logic [TICK_W-1:0] now);
        logic [TICK_W-1:0] age;
        while (live_cnt[ring] > 0) begin
            age = now - stamp_log[ring][head_slot[ring]];
            if (age <= window_len) break;
            head_slot[ring] = (head_slot[ring] + 1) % RING_DEPTH;
            live_cnt[ring]--;
        end
    endfunction

    // Advance the shadow by one item and return the result it must produce
    function automatic result_t tally_window(logic act, logic kind, logic [7:0] sndr,
                                             logic [TICK_W-1:0] now);
        result_t r;
        int ring;
        int slot;
        r = '0;
        if (int'(sndr) >= NUM_SENDERS) return r;
        ring = int'(kind) * NUM_SENDERS + int'(sndr);
        if (act == ACT_RECORD) begin
            if (live_cnt[ring] >= RING_DEPTH) begin
                // full ring: overwrite the oldest stamp
                slot = head_slot[ring];
                head_slot[ring] = (slot + 1) % RING_DEPTH;
                r.history_full = 1'b1;
            end else begin
                slot = (head_slot[ring] + live_cnt[ring]) % RING_DEPTH;
                live_cnt[ring]++;
            end
            stamp_log[ring][slot] = now;
            drop_stale(ring, now);
        end else begin
            drop_stale(ring, now);
            r.over_limit = live_cnt[ring] > int'((kind == KIND_CMD) ? max_cmds : max_msgs);
        end
        r.recent_count = COUNT_OUT_W'(live_cnt[ring]);
        return r;
    endfunction

    // Offer one item, hold it until accepted, then queue its expected result
    task automatic offer(logic act, logic kind, logic [7:0] sndr, logic [TICK_W-1:0] now,
                         bit typed, result_t typed_res);
        result_t r;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {now, sndr};
        s_tuser  <= {kind, act};
        do @(posedge aclk); while (!s_tready);
        r = tally_window(act, kind, sndr, now);
        tallies_due.insert(tallies_due.size(), typed ? typed_res : r);
        burst_left--;
    endtask

    // Insert a random gap between bursts of back-to-back items
    task automatic pace();
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic put_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_WINDOW_TICKS: window_len = val;
            CFG_MAX_MESSAGES: max_msgs   = val[LIMIT_W-1:0];
            CFG_MAX_COMMANDS: max_cmds   = val[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Drain every expected result, then let the pipeline go quiet
    task automatic settle(int tail);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tallies_due.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // Stimulus: reset, directed rows, then random phases
    initial begin : stimulus
        probe_t            rows [17];
        result_t           want;
        logic [TICK_W-1:0] cursor;
        logic [TICK_W-1:0] win;
        logic [15:0]       mm;
        logic [15:0]       mc;
        logic              act;
        logic              kind;
        logic [7:0]        sndr;
        int                n_items;
        int                pool;
        int                rec_pct;
        int                cmd_pct;
        int                hot_base;
        int                pick;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset thresholds and window; typed rows follow from the rule directly
        rows = '{
            '{ACT_CHECK,  KIND_MSG, 8'd0,   32'd0,          1, 0, 0, 0},  // empty ring
            '{ACT_RECORD, KIND_MSG, 8'd0,   32'd0,          1, 1, 0, 0},
            '{ACT_RECORD, KIND_MSG, 8'd0,   32'd10000,      1, 2, 0, 0},  // age equals window
            '{ACT_RECORD, KIND_MSG, 8'd0,   32'd10001,      0, 0, 0, 0},
            '{ACT_CHECK,  KIND_MSG, 8'd0,   32'd20001,      0, 0, 0, 0},
            '{ACT_RECORD, KIND_CMD, 8'd255, 32'hFFFF_FFFF,  1, 1, 0, 0},
            '{ACT_RECORD, KIND_CMD, 8'd255, 32'h0000_0004,  0, 0, 0, 0},  // time wraps
            '{ACT_CHECK,  KIND_CMD, 8'd255, 32'h0000_0004,  0, 0, 0, 0},
            '{ACT_RECORD, KIND_MSG, 8'd128, 32'h8000_0000,  1, 1, 0, 0},
            '{ACT_CHECK,  KIND_MSG, 8'd128, 32'h0000_0000,  0, 0, 0, 0},
            '{ACT_RECORD, KIND_CMD, 8'd2,   32'd100,        1, 1, 0, 0},
            '{ACT_RECORD, KIND_CMD, 8'd2,   32'd5000,       0, 0, 0, 0},
            '{ACT_CHECK,  KIND_CMD, 8'd2,   32'd100,        0, 0, 0, 0},  // stale stamp stuck
            '{ACT_CHECK,  KIND_CMD, 8'd2,   32'd15001,      0, 0, 0, 0},
            '{ACT_CHECK,  KIND_MSG, 8'd255, 32'hFFFF_FFFF,  1, 0, 0, 0},
            '{ACT_RECORD, KIND_MSG, 8'hAA,  32'h5555_5555,  1, 1, 0, 0},
            '{ACT_RECORD, KIND_MSG, 8'h55,  32'hAAAA_AAAA,  1, 1, 0, 0}
        };
        foreach (rows[i]) begin
            want = '0;
            want.recent_count = COUNT_OUT_W'(rows[i].cnt);
            want.over_limit   = rows[i].over;
            want.history_full = rows[i].full;
            pace();
            offer(rows[i].act, rows[i].kind, rows[i].sndr, rows[i].now, rows[i].typed, want);
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            settle(10);
            case (p)
                0: begin win = WINDOW_RESET; mm = 16'd10; mc = 16'd10;
                         n_items = 70; pool = 3; rec_pct = 75; cmd_pct = 50; end
                1: begin win = 32'hFFFF_FFFF; mm = 16'd0; mc = 16'hFFFF;
                         n_items = 150; pool = 1; rec_pct = 85; cmd_pct = 10; end
                2: begin win = 32'd1; mm = 16'hFFFF; mc = 16'd0;
                         n_items = 60; pool = 2; rec_pct = 70; cmd_pct = 50; end
                3: begin win = 32'd500; mm = 16'd3; mc = 16'd5;
                         n_items = 70; pool = 2; rec_pct = 70; cmd_pct = 50; end
                4: begin win = $urandom_range(1, 1 << 20);
                         mm = $urandom_range(0, 20); mc = $urandom_range(0, 20);
                         n_items = 80; pool = 3; rec_pct = 70; cmd_pct = 50; end
                default: begin win = $urandom_range(1, 32'hFFFF_FFFF);
                         mm = $urandom_range(0, 65535); mc = $urandom_range(0, 65535);
                         n_items = 70; pool = 4; rec_pct = 65; cmd_pct = 50; end
            endcase
            put_reg(CFG_WINDOW_TICKS, win);
            put_reg(CFG_MAX_MESSAGES, {16'd0, mm});
            put_reg(CFG_MAX_COMMANDS, {16'd0, mc});
            @(negedge aclk);
            cfg_we <= 1'b0;

            cursor   = $urandom;
            hot_base = $urandom_range(0, 256 - pool);
            for (int k = 0; k < n_items; k++) begin
                // advance time: mostly small steps, some repeats, jumps and backward moves
                pick = $urandom_range(0, 99);
                if (pick < 10)      ;
                else if (pick < 75) cursor += $urandom_range(0, (window_len >> 4) + 1);
                else if (pick < 87) cursor += window_len + $urandom_range(0, window_len);
                else if (pick < 95) cursor -= $urandom_range(0, window_len >> 2);
                else                cursor = $urandom;
                act  = ($urandom_range(0, 99) < rec_pct) ? ACT_RECORD : ACT_CHECK;
                kind = ($urandom_range(0, 99) < cmd_pct) ? KIND_CMD : KIND_MSG;
                if ($urandom_range(0, 99) < 85) sndr = 8'(hot_base + $urandom_range(0, pool - 1));
                else                            sndr = 8'($urandom_range(0, 255));
                pace();
                offer(act, kind, sndr, cursor, 1'b0, '0);
            end
        end

        settle(20);
        if (failures == 0) begin
            $display("** sliding_window_rate_limiter_unit: PASSED **");
        end else begin
            $display("** sliding_window_rate_limiter_unit: FAILED **");
        end
        $finish;
    end

    // Result side: stretches of free flow, random stalls, and one long hold-off
    initial begin : result_sink
        int  seg_left;
        int  mode;
        int  hold_left;
        bit  held;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        held      = 0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held      = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(4, 40);
                end
                seg_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[8:0];
            results_seen++;
            if (tallies_due.size() == 0) begin
                $error("unexpected result: m_tdata %h", m_tdata);
                failures++;
            end else begin
                want = tallies_due.pop_front();
                if (got.recent_count !== want.recent_count) begin
                    $error("recent_count: expected %0d, actual %0d",
                           want.recent_count, got.recent_count);
                    failures++;
                end
                if (got.over_limit !== want.over_limit) begin
                    $error("over_limit: expected %0d, actual %0d",
                           want.over_limit, got.over_limit);
                    failures++;
                end
                if (got.history_full !== want.history_full) begin
                    $error("history_full: expected %0d, actual %0d",
                           want.history_full, got.history_full);
                    failures++;
                end
                if (m_tdata[15:9] !== '0) begin
                    $error("padding: expected 0, actual %h", m_tdata[15:9]);
                    failures++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin : watchdog
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $error("timeout: no item accepted for %0d cycles", QUIET_LIMIT);
                $display("** sliding_window_rate_limiter_unit: FAILED **");
                $finish;
            end
        end
    end

endmodule
